// ----- design/b2d_pkg.sv -----
package b2d_pkg;

   // Opcode codes
   localparam logic OP_SIGNED   = 1'b0;
   localparam logic OP_UNSIGNED = 1'b1;

   // ASCII codes
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   // Decimal place weights
   localparam logic [15:0] PLACE_10K = 16'd10000;
   localparam logic [15:0] PLACE_1K  = 16'd1000;
   localparam logic [15:0] PLACE_100 = 16'd100;
   localparam logic [15:0] PLACE_10  = 16'd10;

   // Characters per converted word: sign plus five digits
   localparam logic [2:0] CHAR_COUNT = 3'd6;

   // Tail of the digit pipeline, handed to the serializer
   typedef struct packed {
      logic       valid;
      logic       neg;
      logic [3:0] d4;
      logic [3:0] d3;
      logic [3:0] d2;
      logic [6:0] rem;
   } tail_type;

   // One decimal digit: nine parallel compares against k*place, then one subtract.
   // Called with a constant place, so the products fold away.
   // Returns {digit, remainder}.
   function automatic logic [19:0] dec_step(input logic [15:0] rem,
                                            input logic [15:0] place);
      logic [3:0]  dig;
      logic [15:0] r;
      logic [19:0] lim;
      dig = 4'd0;
      r   = rem;
      for (int k = 1; k <= 9; k++) begin
         lim = 20'(k) * {4'd0, place};
         if ({4'd0, rem} >= lim) begin
            dig = 4'(k);
            r   = 16'({4'd0, rem} - lim);
         end
      end
      return {dig, r};
   endfunction

endpackage

// ----- design/b2d_convert.sv -----
// Five-stage digit pipeline: capture, magnitude, then one digit per stage.
module b2d_convert (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        in_value,
   input  logic               in_opcode,
   output logic               busy,
   input  logic               sink_ready,
   output b2d_pkg::tail_type  tail
);

   logic [4:0]  valid_ff, valid_in;
   logic [4:0]  move;

   logic [15:0] value_ff;
   logic        opcode_ff;

   logic        neg1_ff, neg1_in;
   logic [15:0] mag1_ff, mag1_in;

   logic        neg2_ff;
   logic [3:0]  d4_2_ff;
   logic [13:0] rem2_ff;

   logic        neg3_ff;
   logic [3:0]  d4_3_ff, d3_3_ff;
   logic [9:0]  rem3_ff;

   logic        neg4_ff;
   logic [3:0]  d4_4_ff, d3_4_ff, d2_4_ff;
   logic [6:0]  rem4_ff;

   logic [19:0] step2, step3, step4;

   // a stage takes new contents when empty or when its own contents leave
   always_comb begin
      move[4] = !valid_ff[4] || sink_ready;
      move[3] = !valid_ff[3] || move[4];
      move[2] = !valid_ff[2] || move[3];
      move[1] = !valid_ff[1] || move[2];
      move[0] = !valid_ff[0] || move[1];
   end

   assign busy = !move[0];

   always_comb begin
      valid_in[0] = move[0] ? start       : valid_ff[0];
      valid_in[1] = move[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = move[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = move[3] ? valid_ff[2] : valid_ff[3];
      valid_in[4] = move[4] ? valid_ff[3] : valid_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // two's complement magnitude; 0x8000 gives 32768, still fits 16 bits
   always_comb begin
      neg1_in = (opcode_ff == b2d_pkg::OP_SIGNED) && value_ff[15];
      mag1_in = neg1_in ? (~value_ff + 16'd1) : value_ff;
   end

   assign step2 = b2d_pkg::dec_step(mag1_ff, b2d_pkg::PLACE_10K);
   assign step3 = b2d_pkg::dec_step({2'd0, rem2_ff}, b2d_pkg::PLACE_1K);
   assign step4 = b2d_pkg::dec_step({6'd0, rem3_ff}, b2d_pkg::PLACE_100);

   always_ff @(posedge clock) begin
      if (move[0]) begin
         value_ff  <= in_value;
         opcode_ff <= in_opcode;
      end
      if (move[1]) begin
         neg1_ff <= neg1_in;
         mag1_ff <= mag1_in;
      end
      if (move[2]) begin
         neg2_ff <= neg1_ff;
         d4_2_ff <= step2[19:16];
         rem2_ff <= step2[13:0];
      end
      if (move[3]) begin
         neg3_ff <= neg2_ff;
         d4_3_ff <= d4_2_ff;
         d3_3_ff <= step3[19:16];
         rem3_ff <= step3[9:0];
      end
      if (move[4]) begin
         neg4_ff <= neg3_ff;
         d4_4_ff <= d4_3_ff;
         d3_4_ff <= d3_3_ff;
         d2_4_ff <= step4[19:16];
         rem4_ff <= step4[6:0];
      end
   end

   always_comb begin
      tail.valid = valid_ff[4];
      tail.neg   = neg4_ff;
      tail.d4    = d4_4_ff;
      tail.d3    = d3_4_ff;
      tail.d2    = d2_4_ff;
      tail.rem   = rem4_ff;
   end

endmodule

// ----- design/b2d_serial.sv -----
// Last two digits, then a six-character shift register.
module b2d_serial (
   input  logic              clock,
   input  logic              reset,
   input  b2d_pkg::tail_type tail,
   output logic              sink_ready,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_character,
   output logic              rsp_last
);

   logic [2:0]  cnt_ff, cnt_in;
   logic [47:0] shift_ff, shift_in;
   logic        load;
   logic [19:0] step5;
   logic [7:0]  sign_char;

   // free now, or emitting its final beat this cycle
   assign sink_ready = (cnt_ff == 3'd0) || (cnt_ff == 3'd1);
   assign load       = tail.valid && sink_ready;

   assign step5     = b2d_pkg::dec_step({9'd0, tail.rem}, b2d_pkg::PLACE_10);
   assign sign_char = tail.neg ? b2d_pkg::ASCII_MINUS : b2d_pkg::ASCII_ZERO;

   always_comb begin
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      if (load) begin
         cnt_in   = b2d_pkg::CHAR_COUNT;
         shift_in = {sign_char,
                     b2d_pkg::ASCII_ZERO | {4'd0, tail.d4},
                     b2d_pkg::ASCII_ZERO | {4'd0, tail.d3},
                     b2d_pkg::ASCII_ZERO | {4'd0, tail.d2},
                     b2d_pkg::ASCII_ZERO | {4'd0, step5[19:16]},
                     b2d_pkg::ASCII_ZERO | {4'd0, step5[3:0]}};
      end else if (cnt_ff != 3'd0) begin
         cnt_in   = cnt_ff - 3'd1;
         shift_in = {shift_ff[39:0], 8'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign rsp_strobe    = (cnt_ff != 3'd0);
   assign rsp_character = shift_ff[47:40];
   assign rsp_last      = (cnt_ff == 3'd1);

endmodule

// ----- design/binary_to_decimal_ascii.sv -----
// The first character is shown once the word has passed the digit pipeline and loaded the serializer.
// The output serializer takes a new word as the six characters of the previous one finish; words
//   queue in the five-stage digit pipeline and busy rises only when it is full.
// The receiver cannot stall: each result beat stands for exactly one cycle.
// Reset (synchronous, active high) empties the pipeline and the serializer; no beat
//   is shown and busy is low in the cycle after reset.
module binary_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   // request channel: accepted when start && !busy
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_value,
   input  logic        req_opcode,
   // result channel: one character per strobe
   output logic        rsp_strobe,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);

   b2d_pkg::tail_type tail;
   logic              sink_ready;

   // Stage 0 captures the word, stage 1 forms sign and magnitude,
   // stages 2..4 peel off ten-thousands, thousands and hundreds.
   // Each stage holds its contents while the one after it is full and cannot move on.
   b2d_convert u_convert (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .in_value   (req_value),
      .in_opcode  (req_opcode),
      .busy       (busy),
      .sink_ready (sink_ready),
      .tail       (tail)
   );

   // Tens and units are split off on load; the six characters then
   // shift out, sign first. A new word loads on the final beat of the
   // previous one, so runs follow each other without a gap.
   b2d_serial u_serial (
      .clock         (clock),
      .reset         (reset),
      .tail          (tail),
      .sink_ready    (sink_ready),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- design/b2d_check.sv -----
module b2d_check (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [7:0]  rsp_character,
   input logic        rsp_last
);

   // last flag only on a live beat
   a_last_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("last without strobe");

   // a six-character run has no gaps
   a_run_contig: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside a character run");

   // every character is a digit or a minus sign
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_character == b2d_pkg::ASCII_MINUS ||
                      (rsp_character >= b2d_pkg::ASCII_ZERO &&
                       rsp_character <= b2d_pkg::ASCII_NINE)))
      else $error("character outside digit set");

   // a minus sign appears only as the first beat of a run
   a_minus_first: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !$past(rsp_last) && $past(rsp_strobe) |->
         rsp_character != b2d_pkg::ASCII_MINUS)
      else $error("minus sign inside digits");

   // reset leaves the block empty and ready
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_strobe && !busy)
      else $error("activity right after reset");

endmodule

bind binary_to_decimal_ascii b2d_check u_check (.*);

// ----- verif/tb.sv -----
module tb;

   // One word to convert. text holds the six expected characters, first char in
   // the top byte; all zeros means "work it out with decimal_text".
   typedef struct packed {
      logic [15:0] value;
      logic        opcode;
      logic [47:0] text;
   } word_vector_type;

   // One result beat as the receiver should see it
   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } char_beat_type;

   localparam logic [47:0] BY_MODEL = 48'd0;
   // Longest stretch with no beat on either side in a correct run is a sender
   // gap plus the pipeline latency; allow far more.
   localparam int WATCHDOG_LIMIT = 2000;
   // Quiet time after the last expected character, beyond the pipeline latency
   localparam int DRAIN_CYCLES = 24;
   localparam int NUM_RANDOM = 388;
   localparam int NUM_DIRECTED = 22;

   // Directed words: extremes of both modes, the most negative signed word,
   // unsigned words with the top bit set, and decimal place boundaries.
   localparam word_vector_type DIRECTED [NUM_DIRECTED] = '{
      '{16'h0000, b2d_pkg::OP_SIGNED,   "000000"},
      '{16'h0001, b2d_pkg::OP_SIGNED,   "000001"},
      '{16'h7FFF, b2d_pkg::OP_SIGNED,   "032767"},
      '{16'h8000, b2d_pkg::OP_SIGNED,   "-32768"},   // magnitude must not overflow
      '{16'h8001, b2d_pkg::OP_SIGNED,   "-32767"},
      '{16'hFFFF, b2d_pkg::OP_SIGNED,   "-00001"},
      '{16'hD8F0, b2d_pkg::OP_SIGNED,   "-10000"},
      '{16'hD8F1, b2d_pkg::OP_SIGNED,   "-09999"},
      '{16'h5555, b2d_pkg::OP_SIGNED,   "021845"},
      '{16'hAAAA, b2d_pkg::OP_SIGNED,   "-21846"},
      '{16'h0000, b2d_pkg::OP_UNSIGNED, "000000"},
      '{16'hFFFF, b2d_pkg::OP_UNSIGNED, "065535"},   // sign char stays '0' in unsigned mode
      '{16'h8000, b2d_pkg::OP_UNSIGNED, "032768"},
      '{16'h7FFF, b2d_pkg::OP_UNSIGNED, "032767"},
      '{16'h2710, b2d_pkg::OP_UNSIGNED, "010000"},
      '{16'h270F, b2d_pkg::OP_UNSIGNED, "009999"},
      '{16'hAAAA, b2d_pkg::OP_UNSIGNED, "043690"},
      '{16'h5555, b2d_pkg::OP_UNSIGNED, "021845"},
      '{16'h1234, b2d_pkg::OP_SIGNED,   BY_MODEL},
      '{16'hFEDC, b2d_pkg::OP_UNSIGNED, BY_MODEL},
      '{16'hC350, b2d_pkg::OP_SIGNED,   BY_MODEL},
      '{16'hC350, b2d_pkg::OP_UNSIGNED, BY_MODEL}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_value = 16'd0;
   logic        req_opcode = b2d_pkg::OP_SIGNED;
   logic        rsp_strobe;
   logic [7:0]  rsp_character;
   logic        rsp_last;

   word_vector_type word_queue[$];      // words not yet offered
   word_vector_type word_on_bus;        // word currently driven with start
   char_beat_type   pending_chars[$];   // characters still to come, oldest first
   int              mismatch_count = 0;
   int              chars_seen = 0;
   int              burst_left = 1;
   int              gap_left = 0;

   binary_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_opcode    (req_opcode),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Six ASCII chars for one word: sign, then five digits with leading zeros.
   // Magnitude is kept 32 bits wide so 0x8000 signed gives 32768 cleanly.
   function automatic logic [47:0] decimal_text(input logic [15:0] value,
                                                input logic opcode);
      logic [47:0] text;
      int unsigned magnitude;
      int unsigned place;
      int unsigned digit;
      magnitude = value;
      place = 10000;
      text[47:40] = b2d_pkg::ASCII_ZERO;
      if (opcode == b2d_pkg::OP_SIGNED && value[15]) begin
         magnitude = 32'h10000 - value;
         text[47:40] = b2d_pkg::ASCII_MINUS;
      end
      for (int k = 0; k < 5; k++) begin
         digit = magnitude / place;
         magnitude = magnitude - digit * place;
         text[39 - 8 * k -: 8] = b2d_pkg::ASCII_ZERO + 8'(digit);
         place = place / 10;
      end
      return text;
   endfunction

   function automatic word_vector_type random_word();
      word_vector_type w;
      int unsigned place;
      w.text = BY_MODEL;
      w.opcode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         6: w.value = 16'(32'h7FFB + $urandom_range(0, 10));   // around the sign flip
         7: begin
            w.value = 16'($urandom_range(0, 20));
            if ($urandom_range(0, 1) == 1) w.value = ~w.value;   // small negatives
         end
         8: begin
            // a digit place rolling over: k*place - 1, k*place, k*place + 1
            case ($urandom_range(0, 3))
               0: place = 10;
               1: place = 100;
               2: place = 1000;
               default: place = 10000;
            endcase
            w.value = 16'(place * $urandom_range(1, 6) + $urandom_range(0, 2) - 1);
         end
         9: begin
            case ($urandom_range(0, 2))
               0: w.value = 16'h0000;
               1: w.value = 16'hFFFF;
               default: w.value = 16'h8000;
            endcase
         end
         default: w.value = 16'($urandom());
      endcase
      return w;
   endfunction

   task automatic queue_chars(input logic [47:0] text);
      char_beat_type beat;
      for (int i = 0; i < 6; i++) begin
         beat.character = text[47 - 8 * i -: 8];
         beat.last = (i == 5);
         pending_chars.push_back(beat);
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at char %0d: %s", chars_seen, what);
      mismatch_count++;
   endtask

   // Sender: bursts of back-to-back words with random gaps between them.
   // start is held (one NBA per edge at most) while busy blocks the beat.
   always @(posedge clock) begin
      word_vector_type next_word;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            if (word_on_bus.text != BY_MODEL) queue_chars(word_on_bus.text);
            else queue_chars(decimal_text(word_on_bus.value, word_on_bus.opcode));
         end
         if (start && busy) begin
            // hold the current word until it is taken
         end else if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (word_queue.size() != 0) begin
            next_word = word_queue.pop_front();
            word_on_bus <= next_word;
            req_value <= next_word.value;
            req_opcode <= next_word.opcode;
            start <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 25);
               case ($urandom_range(0, 9))
                  0, 1: gap_left = 0;                          // run straight on
                  2, 3, 4, 5, 6: gap_left = $urandom_range(1, 6);  // every phase of a six-character run
                  default: gap_left = $urandom_range(7, 20);   // let the pipeline empty
               endcase
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Receiver: every strobe must match the oldest pending character.
   always @(posedge clock) begin
      char_beat_type want;
      if (!reset && rsp_strobe) begin
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                      rsp_character, rsp_last));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_character !== want.character)
               report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                         rsp_character, want.character));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
         end
         chars_seen++;
      end
   end

   // Watchdog: ends the run when neither side has moved a beat for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      for (int i = 0; i < NUM_DIRECTED; i++) word_queue.push_back(DIRECTED[i]);
      for (int i = 0; i < NUM_RANDOM; i++) word_queue.push_back(random_word());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Checked at the falling edge so the sender and receiver have settled.
      @(negedge clock);
      while (word_queue.size() != 0 || start || pending_chars.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
